// File: hw/rtl/eotd_pkg.sv
// Shared types and constants for the audio end-of-track detector.
// No dependencies; used by every module of the block.
package eotd_pkg;

  // register file
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  localparam logic [1:0] REG_ACTIVITY_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_SILENCE_FRAMES     = 2'd1;
  localparam logic [1:0] REG_MAX_FRAMES         = 2'd2;
  localparam logic [1:0] REG_PASS_FRAMES        = 2'd3;

  localparam logic [22:0] ACTIVITY_THRESHOLD_RST = 23'd1280;
  localparam logic [23:0] SILENCE_FRAMES_RST     = 24'd250;
  localparam logic [23:0] MAX_FRAMES_RST         = 24'd180000;
  localparam logic [23:0] PASS_FRAMES_RST        = 24'd9000;

  localparam int SAMPLE_W = 16;
  localparam int SUM_W    = 17;
  localparam int ACC_W    = 23;
  localparam int OUT_W    = 24;

  typedef enum logic [1:0] {
    ST_RUNNING,
    ST_SILENCE_END,
    ST_UPDATE_END,
    ST_MAX_REACHED
  } status_t;

  typedef struct packed {
    logic [22:0] activity_threshold;
    logic [23:0] silence_frames;
    logic [23:0] max_frames;
    logic [23:0] pass_frames;
  } cfg_t;

  // one slice-level item from the delta stage to the evaluator
  typedef struct packed {
    logic              restart;
    logic              slice_end;
    logic              idle_slice;
    logic              frame_changed;
    logic [ACC_W-1:0]  slice_sum;
  } slice_t;

  typedef struct packed {
    status_t           status;
    logic [OUT_W-1:0]  end_frame;
    logic [OUT_W-1:0]  frame_count;
  } result_t;

endpackage

// File: hw/rtl/audio_end_of_track_detector.sv
// Audio end-of-track detector, top level.
// A slice-end item passes the input register, the slice item register and the result register.
// Throughput: one item per cycle while m_tready does not stall the result;
// the delta accumulator and the frame-state update each close their loop.
// Reset (rst, synchronous): clears all running state, loads register defaults.
// Depends on eotd_pkg, eotd_cfg, eotd_delta, eotd_eval.
module audio_end_of_track_detector #(
  parameter int FRAME_BITS = 24
) (
  input  logic                        clk,
  input  logic                        rst,
  // input items
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [31:0]                 s_tdata,  // left_sample[15:0], right_sample[31:16]
  input  logic                        s_tlast,  // slice_end
  input  logic [2:0]                  s_tuser,  // restart[0], idle_slice[1], frame_changed[2]
  // result items
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [47:0]                 m_tdata,  // end_frame[23:0], frame_count[47:24]
  output logic [1:0]                  m_tuser,  // status[1:0]
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [eotd_pkg::ADDR_W-1:0] paddr,
  input  logic [eotd_pkg::DATA_W-1:0] pwdata,
  output logic [eotd_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);

  eotd_pkg::cfg_t    cfg;
  eotd_pkg::slice_t  item;
  eotd_pkg::result_t res;
  logic              item_valid;
  logic              item_ready;

  eotd_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  eotd_delta u_delta (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .in_restart   (s_tuser[0]),
    .in_left      (s_tdata[15:0]),
    .in_right     (s_tdata[31:16]),
    .in_slice_end (s_tlast),
    .in_idle      (s_tuser[1]),
    .in_changed   (s_tuser[2]),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item)
  );

  eotd_eval #(
    .FRAME_BITS (FRAME_BITS)
  ) u_eval (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .res_valid  (m_tvalid),
    .res_ready  (m_tready),
    .res        (res)
  );

  assign m_tdata = {res.frame_count, res.end_frame};
  assign m_tuser = res.status;

endmodule

// File: hw/rtl/eotd_cfg.sv
// APB-style configuration registers of the end-of-track detector.
// Depends on eotd_pkg.
module eotd_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [eotd_pkg::ADDR_W-1:0] paddr,
  input  logic [eotd_pkg::DATA_W-1:0] pwdata,
  output logic [eotd_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output eotd_pkg::cfg_t              cfg
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.activity_threshold <= eotd_pkg::ACTIVITY_THRESHOLD_RST;
      cfg.silence_frames     <= eotd_pkg::SILENCE_FRAMES_RST;
      cfg.max_frames         <= eotd_pkg::MAX_FRAMES_RST;
      cfg.pass_frames        <= eotd_pkg::PASS_FRAMES_RST;
    end else if (wr_en) begin
      case (paddr[3:2])
        eotd_pkg::REG_ACTIVITY_THRESHOLD: cfg.activity_threshold <= pwdata[22:0];
        eotd_pkg::REG_SILENCE_FRAMES:     cfg.silence_frames     <= pwdata[23:0];
        eotd_pkg::REG_MAX_FRAMES:         cfg.max_frames         <= pwdata[23:0];
        eotd_pkg::REG_PASS_FRAMES:        cfg.pass_frames        <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      eotd_pkg::REG_ACTIVITY_THRESHOLD:
        prdata = eotd_pkg::DATA_W'(cfg.activity_threshold);
      eotd_pkg::REG_SILENCE_FRAMES: prdata = eotd_pkg::DATA_W'(cfg.silence_frames);
      eotd_pkg::REG_MAX_FRAMES:     prdata = eotd_pkg::DATA_W'(cfg.max_frames);
      eotd_pkg::REG_PASS_FRAMES:    prdata = eotd_pkg::DATA_W'(cfg.pass_frames);
      default:                      prdata = '0;
    endcase
  end

endmodule

// File: hw/rtl/eotd_delta.sv
// Input register and per-sample delta accumulation (left+right, abs diff).
// Depends on eotd_pkg; feeds slice-level items to eotd_eval.
module eotd_delta (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_restart,
  input  logic [eotd_pkg::SAMPLE_W-1:0] in_left,
  input  logic [eotd_pkg::SAMPLE_W-1:0] in_right,
  input  logic                          in_slice_end,
  input  logic                          in_idle,
  input  logic                          in_changed,
  output logic                          item_valid,
  input  logic                          item_ready,
  output eotd_pkg::slice_t              item
);

  localparam int SW = eotd_pkg::SUM_W;
  localparam int DW = SW + 1;
  localparam int AW = eotd_pkg::ACC_W;

  // input register
  logic                          vi;
  logic                          r_restart;
  logic signed [eotd_pkg::SAMPLE_W-1:0] r_left;
  logic signed [eotd_pkg::SAMPLE_W-1:0] r_right;
  logic                          r_slice_end;
  logic                          r_idle;
  logic                          r_changed;

  // running state
  logic signed [SW-1:0] previous_sum;
  logic [AW-1:0]        delta_acc;

  logic                 adv;
  logic signed [SW-1:0] prev_eff;
  logic [AW-1:0]        acc_eff;
  logic signed [SW-1:0] sum;
  logic signed [DW-1:0] dif;
  logic [SW-1:0]        dif_abs;
  logic [AW:0]          acc_wide;
  logic [AW-1:0]        acc_next;

  assign adv      = vi && (!item_valid || item_ready);
  assign in_ready = !vi || adv;

  always_comb begin
    prev_eff = r_restart ? '0 : previous_sum;
    acc_eff  = r_restart ? '0 : delta_acc;
    sum      = SW'(r_left) + SW'(r_right);
    dif      = DW'(sum) - DW'(prev_eff);
    dif_abs  = dif[DW-1] ? SW'(-dif) : SW'(dif);
    acc_wide = (AW+1)'(acc_eff) + (AW+1)'(dif_abs);
    // saturate the slice delta sum
    acc_next = acc_wide[AW] ? '1 : acc_wide[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vi           <= 1'b0;
      item_valid   <= 1'b0;
      previous_sum <= '0;
      delta_acc    <= '0;
    end else begin
      if (in_ready) begin
        vi <= in_valid;
      end
      if (adv) begin
        previous_sum <= sum;
        delta_acc    <= r_slice_end ? '0 : acc_next;
        // only slice ends and restarts matter downstream
        item_valid   <= r_restart || r_slice_end;
      end else if (item_ready) begin
        item_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      r_restart   <= in_restart;
      r_left      <= in_left;
      r_right     <= in_right;
      r_slice_end <= in_slice_end;
      r_idle      <= in_idle;
      r_changed   <= in_changed;
    end
    if (adv) begin
      item.restart       <= r_restart;
      item.slice_end     <= r_slice_end;
      item.idle_slice    <= r_idle;
      item.frame_changed <= r_changed;
      item.slice_sum     <= acc_next;
    end
  end

endmodule

// File: hw/rtl/eotd_eval.sv
// Slice evaluation: silence tracking, frame counting, pass-based end detection,
// and the result register. Depends on eotd_pkg.
module eotd_eval #(
  parameter int FRAME_BITS = 24
) (
  input  logic              clk,
  input  logic              rst,
  input  eotd_pkg::cfg_t    cfg,
  input  logic              item_valid,
  output logic              item_ready,
  input  eotd_pkg::slice_t  item,
  output logic              res_valid,
  input  logic              res_ready,
  output eotd_pkg::result_t res
);

  localparam int FB = FRAME_BITS;
  localparam int OW = eotd_pkg::OUT_W;
  localparam int CW = (FB > OW) ? FB : OW;
  localparam int PW = CW + 1;
  localparam logic [PW-1:0] FRAME_MAX = PW'({FB{1'b1}});

  logic [FB-1:0] frame_counter;
  logic [FB-1:0] silence_start;
  logic          silence_active;
  logic [FB-1:0] last_update_frame;
  logic          update_seen;
  logic          updated_this_pass;
  logic [FB-1:0] pass_limit;
  logic          finished;

  // state after an optional restart
  logic [FB-1:0] c_fc, c_ss, c_lu, c_pl;
  logic          c_sa, c_us, c_utp, c_fin;

  logic [FB-1:0] fc_next, ss_next, lu_next, pl_next;
  logic          sa_next, us_next, utp_next, fin_next;

  logic              emit;
  eotd_pkg::status_t st;
  logic [OW-1:0]     end_frame;
  logic [FB-1:0]     silence_len;
  logic [PW-1:0]     pl_sum;
  logic              take;

  assign item_ready = !res_valid || res_ready;
  assign take       = item_valid && item_ready;

  always_comb begin
    if (item.restart) begin
      c_fc  = '0;
      c_ss  = '0;
      c_sa  = 1'b0;
      c_lu  = '0;
      c_us  = 1'b0;
      c_utp = 1'b0;
      c_pl  = FB'(cfg.pass_frames);
      c_fin = 1'b0;
    end else begin
      c_fc  = frame_counter;
      c_ss  = silence_start;
      c_sa  = silence_active;
      c_lu  = last_update_frame;
      c_us  = update_seen;
      c_utp = updated_this_pass;
      c_pl  = pass_limit;
      c_fin = finished;
    end
  end

  always_comb begin
    fc_next     = c_fc;
    ss_next     = c_ss;
    sa_next     = c_sa;
    lu_next     = c_lu;
    us_next     = c_us;
    utp_next    = c_utp;
    pl_next     = c_pl;
    fin_next    = c_fin;
    emit        = 1'b0;
    st          = eotd_pkg::ST_RUNNING;
    end_frame   = '0;
    silence_len = '0;
    pl_sum      = PW'(c_pl) + PW'(cfg.pass_frames);

    if (!c_fin && item.slice_end) begin
      emit = 1'b1;
      if (item.slice_sum >= cfg.activity_threshold) begin
        sa_next = 1'b0;
      end else if (!c_sa) begin
        sa_next = 1'b1;
        ss_next = c_fc;
      end
      silence_len = c_fc - ss_next;

      if ((cfg.silence_frames != '0) && sa_next &&
          (CW'(silence_len) > CW'(cfg.silence_frames))) begin
        st        = eotd_pkg::ST_SILENCE_END;
        end_frame = OW'(ss_next);
      end else if (!item.idle_slice) begin
        if (item.frame_changed) begin
          lu_next  = c_fc;
          us_next  = 1'b1;
          utp_next = 1'b1;
        end
        fc_next = c_fc + FB'(1);
        if (CW'(fc_next) > CW'(cfg.max_frames)) begin
          st = eotd_pkg::ST_MAX_REACHED;
        end else if (fc_next > c_pl) begin
          if (!utp_next && us_next) begin
            st        = eotd_pkg::ST_UPDATE_END;
            end_frame = OW'(lu_next);
          end else begin
            pl_next  = (pl_sum > FRAME_MAX) ? '1 : pl_sum[FB-1:0];
            utp_next = 1'b0;
          end
        end
      end
      // any nonzero status is terminal until restart
      if (st != eotd_pkg::ST_RUNNING) begin
        fin_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_counter     <= '0;
      silence_start     <= '0;
      silence_active    <= 1'b0;
      last_update_frame <= '0;
      update_seen       <= 1'b0;
      updated_this_pass <= 1'b0;
      pass_limit        <= FB'(eotd_pkg::PASS_FRAMES_RST);
      finished          <= 1'b0;
      res_valid         <= 1'b0;
    end else begin
      if (take) begin
        frame_counter     <= fc_next;
        silence_start     <= ss_next;
        silence_active    <= sa_next;
        last_update_frame <= lu_next;
        update_seen       <= us_next;
        updated_this_pass <= utp_next;
        pass_limit        <= pl_next;
        finished          <= fin_next;
      end
      if (take && emit) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && emit) begin
      res.status      <= st;
      res.end_frame   <= end_frame;
      res.frame_count <= OW'(fc_next);
    end
  end

endmodule
